FILE: rtl/sbc_pkg.sv
`default_nettype none
package sbc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int PARAM_FRAC_BITS = 24;

    localparam int COORD_W  = 32;
    localparam int DEN_W    = COORD_W + 1;
    localparam int NUM_W    = COORD_W + 2;
    localparam int DIV_STEPS = PARAM_FRAC_BITS + 1;
    localparam int Q_W      = PARAM_FRAC_BITS + 2;
    localparam int T_W      = PARAM_FRAC_BITS + 3;
    localparam int PROD_W   = DEN_W + PARAM_FRAC_BITS;
    // abs register, seed stage, one stage per quotient bit, rounding register
    localparam int DIV_LAT  = DIV_STEPS + 3;

    localparam logic signed [T_W-1:0] T_ONE = T_W'(1) <<< PARAM_FRAC_BITS;
    localparam logic signed [T_W-1:0] T_LO  = -T_ONE;
    localparam logic signed [T_W-1:0] T_HI  = T_ONE <<< 1;

    typedef enum logic [1:0] {
        CFG_X_MIN  = 2'd0,
        CFG_Y_MIN  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic zero;
        logic lo_sat;
        logic hi_sat;
        logic neg;
    } div_flags_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [DEN_W-1:0]   dx;
        logic signed [DEN_W-1:0]   dy;
        logic                      x_in;
        logic                      y_in;
    } side_t;

endpackage
`default_nettype wire

FILE: rtl/sbc_div.sv
`default_nettype none
module sbc_div (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [sbc_pkg::NUM_W-1:0]      num,
    input  wire logic signed [sbc_pkg::DEN_W-1:0]      den,
    output logic signed [sbc_pkg::T_W-1:0]             ratio
);

    localparam int NW = sbc_pkg::NUM_W;
    localparam int DW = sbc_pkg::DEN_W;
    localparam int QW = sbc_pkg::Q_W;
    localparam int NS = sbc_pkg::DIV_STEPS;
    localparam int TW = sbc_pkg::T_W;

    logic [NW-1:0] an_reg;
    logic [DW-1:0] ad_reg;
    logic          neg_reg;

    logic [DW-1:0]        r_reg   [NS+1];
    logic [DW-1:0]        d_reg   [NS+1];
    logic [QW-1:0]        q_reg   [NS+1];
    sbc_pkg::div_flags_t  f_reg   [NS+1];
    logic signed [TW-1:0] ratio_reg;

    logic                 ge1, ge2;
    logic [NW-1:0]        an_minus;
    logic [DW-1:0]        r_seed;
    sbc_pkg::div_flags_t  f_seed;
    logic [QW:0]          q_round;
    logic signed [TW-1:0] mag;

    always_comb
    begin
        ge1      = an_reg >= {1'b0, ad_reg};
        ge2      = an_reg >= {ad_reg, 1'b0};
        an_minus = an_reg - {1'b0, ad_reg};
        r_seed   = ge1 ? an_minus[DW-1:0] : an_reg[DW-1:0];
        f_seed.zero   = an_reg == '0;
        f_seed.lo_sat = neg_reg && ge1;
        f_seed.hi_sat = !neg_reg && ge2;
        f_seed.neg    = neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg  <= num[NW-1] ? NW'(-num) : num;
            ad_reg  <= den[DW-1] ? DW'(-den) : den;
            neg_reg <= num[NW-1] ^ den[DW-1];
            r_reg[0] <= r_seed;
            d_reg[0] <= ad_reg;
            q_reg[0] <= {{(QW-1){1'b0}}, ge1};
            f_reg[0] <= f_seed;
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        logic [DW:0] rs;
        logic [DW:0] rd;
        logic        ge;
        always_comb
        begin
            rs = {r_reg[k-1], 1'b0};
            ge = rs >= {1'b0, d_reg[k-1]};
            rd = rs - {1'b0, d_reg[k-1]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? rd[DW-1:0] : rs[DW-1:0];
                d_reg[k] <= d_reg[k-1];
                q_reg[k] <= {q_reg[k-1][QW-2:0], ge};
                f_reg[k] <= f_reg[k-1];
            end
        end
    end

    always_comb
    begin
        q_round = {1'b0, q_reg[NS]} + (QW+1)'(1);
        mag     = $signed({1'b0, q_round[QW:1]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (f_reg[NS].zero)
                ratio_reg <= '0;
            else if (f_reg[NS].lo_sat)
                ratio_reg <= sbc_pkg::T_LO;
            else if (f_reg[NS].hi_sat)
                ratio_reg <= sbc_pkg::T_HI;
            else
                ratio_reg <= f_reg[NS].neg ? -mag : mag;
        end
    end

    assign ratio = ratio_reg;

endmodule
`default_nettype wire

FILE: rtl/sbc_interp.sv
`default_nettype none
module sbc_interp (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic signed [sbc_pkg::COORD_W-1:0]     s,
    input  wire logic [sbc_pkg::DEN_W-1:0]              mag,
    input  wire logic                                   neg,
    input  wire logic [sbc_pkg::PARAM_FRAC_BITS-1:0]    t,
    output logic signed [sbc_pkg::COORD_W-1:0]          pos
);

    localparam int PW = sbc_pkg::PROD_W;
    localparam int FB = sbc_pkg::PARAM_FRAC_BITS;
    localparam int CW = sbc_pkg::COORD_W;

    logic [PW-1:0]        prod_reg;
    logic signed [CW-1:0] s_reg;
    logic                 neg_reg;
    logic [PW-1:0]        rounded;
    logic [CW-1:0]        step;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(mag) * PW'(t);
            s_reg    <= s;
            neg_reg  <= neg;
        end
    end

    always_comb
    begin
        rounded = prod_reg + (PW'(1) << (FB - 1));
        // only the low coordinate bits survive, so a 32-bit add suffices
        step    = rounded[FB +: CW];
        pos     = neg_reg ? CW'(s_reg - $signed(step)) : CW'(s_reg + $signed(step));
    end

endmodule
`default_nettype wire

FILE: rtl/segment_box_clipper_core.sv
// Throughput: one segment per cycle while the output is not stalled;
// the four ratio dividers are fully pipelined, one quotient bit per
// stage, and set the depth. A stalled output beat holds the whole
// pipeline in place.
// Reset (rst_n, async, active low) clears all valid bits and the clip
// rectangle registers to zero.
`default_nettype none
module segment_box_clipper_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             visible,
    output logic signed [31:0] clipped_start_x,
    output logic signed [31:0] clipped_start_y,
    output logic signed [31:0] clipped_end_x,
    output logic signed [31:0] clipped_end_y,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int CW = sbc_pkg::COORD_W;
    localparam int DW = sbc_pkg::DEN_W;
    localparam int NW = sbc_pkg::NUM_W;
    localparam int TW = sbc_pkg::T_W;
    localparam int FB = sbc_pkg::PARAM_FRAC_BITS;
    localparam int DL = sbc_pkg::DIV_LAT;

    logic signed [CW-1:0] x_min_reg, y_min_reg;
    logic [CW-2:0]        width_reg, height_reg;

    logic en;
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg  <= '0;
            y_min_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (sbc_pkg::cfg_idx_t'(cfg_index))
                sbc_pkg::CFG_X_MIN:  x_min_reg  <= cfg_data;
                sbc_pkg::CFG_Y_MIN:  y_min_reg  <= cfg_data;
                sbc_pkg::CFG_WIDTH:  width_reg  <= cfg_data[CW-2:0];
                sbc_pkg::CFG_HEIGHT: height_reg <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // front end: deltas, edge offsets, zero-delta box tests
    logic signed [NW-1:0] x0, x1, y0, y1, sxe, sye;
    sbc_pkg::side_t       side_next;
    always_comb
    begin
        x0  = NW'(x_min_reg);
        y0  = NW'(y_min_reg);
        x1  = x0 + $signed(NW'(width_reg));
        y1  = y0 + $signed(NW'(height_reg));
        sxe = NW'(start_x);
        sye = NW'(start_y);
        side_next.sx   = start_x;
        side_next.sy   = start_y;
        side_next.ex   = end_x;
        side_next.ey   = end_y;
        side_next.dx   = DW'(end_x) - DW'(start_x);
        side_next.dy   = DW'(end_y) - DW'(start_y);
        side_next.x_in = (sxe >= x0) && (sxe <= x1);
        side_next.y_in = (sye >= y0) && (sye <= y1);
    end

    logic                 v2_reg;
    sbc_pkg::side_t       s2_reg;
    logic signed [NW-1:0] nxl_reg, nxh_reg, nyl_reg, nyh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg  <= side_next;
            nxl_reg <= x0 - sxe;
            nxh_reg <= x1 - sxe;
            nyl_reg <= y0 - sye;
            nyh_reg <= y1 - sye;
        end
    end

    logic signed [TW-1:0] rxl, rxh, ryl, ryh;
    sbc_div u_div_xl (.clk(clk), .en(en), .num(nxl_reg), .den(s2_reg.dx), .ratio(rxl));
    sbc_div u_div_xh (.clk(clk), .en(en), .num(nxh_reg), .den(s2_reg.dx), .ratio(rxh));
    sbc_div u_div_yl (.clk(clk), .en(en), .num(nyl_reg), .den(s2_reg.dy), .ratio(ryl));
    sbc_div u_div_yh (.clk(clk), .en(en), .num(nyh_reg), .den(s2_reg.dy), .ratio(ryh));

    sbc_pkg::side_t dl_reg [DL];
    logic [DL-1:0]  dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= s2_reg;
            for (int i = 1; i < DL; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    // slab spans per axis
    sbc_pkg::side_t       s3;
    logic signed [TW-1:0] xin_next, xout_next, yin_next, yout_next;
    logic                 ok_next, zero_next;
    always_comb
    begin
        s3 = dl_reg[DL-1];
        zero_next = (s3.dx == '0) && (s3.dy == '0);
        ok_next   = 1'b1;
        if (s3.dx == '0)
        begin
            xin_next  = sbc_pkg::T_LO;
            xout_next = sbc_pkg::T_HI;
            ok_next   = s3.x_in;
        end
        else
        begin
            xin_next  = (rxl < rxh) ? rxl : rxh;
            xout_next = (rxl < rxh) ? rxh : rxl;
        end
        if (s3.dy == '0)
        begin
            yin_next  = sbc_pkg::T_LO;
            yout_next = sbc_pkg::T_HI;
            ok_next   = ok_next && s3.y_in;
        end
        else
        begin
            yin_next  = (ryl < ryh) ? ryl : ryh;
            yout_next = (ryl < ryh) ? ryh : ryl;
        end
    end

    logic                 v4_reg, ok4_reg, zero4_reg;
    sbc_pkg::side_t       s4_reg;
    logic signed [TW-1:0] xin_reg, xout_reg, yin_reg, yout_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg    <= s3;
            ok4_reg   <= ok_next;
            zero4_reg <= zero_next;
            xin_reg   <= xin_next;
            xout_reg  <= xout_next;
            yin_reg   <= yin_next;
            yout_reg  <= yout_next;
        end
    end

    logic signed [TW-1:0] close, far;
    logic                 vis_next;
    always_comb
    begin
        close    = (xin_reg > yin_reg) ? xin_reg : yin_reg;
        far      = (xout_reg < yout_reg) ? xout_reg : yout_reg;
        vis_next = ok4_reg && !zero4_reg && !(xin_reg > yout_reg) && !(yin_reg > xout_reg)
                   && (far > 0) && (close < sbc_pkg::T_ONE);
    end

    logic                 v5_reg, vis5_reg, use_c5_reg, use_f5_reg;
    logic                 nx5_reg, ny5_reg;
    logic [DW-1:0]        ax5_reg, ay5_reg;
    logic [FB-1:0]        tc5_reg, tf5_reg;
    sbc_pkg::side_t       s5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg     <= s4_reg;
            vis5_reg   <= vis_next;
            use_c5_reg <= close > 0;
            use_f5_reg <= far < sbc_pkg::T_ONE;
            tc5_reg    <= close[FB-1:0];
            tf5_reg    <= far[FB-1:0];
            nx5_reg    <= s4_reg.dx[DW-1];
            ny5_reg    <= s4_reg.dy[DW-1];
            ax5_reg    <= s4_reg.dx[DW-1] ? DW'(-s4_reg.dx) : s4_reg.dx;
            ay5_reg    <= s4_reg.dy[DW-1] ? DW'(-s4_reg.dy) : s4_reg.dy;
        end
    end

    logic signed [CW-1:0] pcsx, pcsy, pcex, pcey;
    sbc_interp u_csx (.clk(clk), .en(en), .s(s5_reg.sx), .mag(ax5_reg), .neg(nx5_reg),
                      .t(tc5_reg), .pos(pcsx));
    sbc_interp u_csy (.clk(clk), .en(en), .s(s5_reg.sy), .mag(ay5_reg), .neg(ny5_reg),
                      .t(tc5_reg), .pos(pcsy));
    sbc_interp u_cex (.clk(clk), .en(en), .s(s5_reg.sx), .mag(ax5_reg), .neg(nx5_reg),
                      .t(tf5_reg), .pos(pcex));
    sbc_interp u_cey (.clk(clk), .en(en), .s(s5_reg.sy), .mag(ay5_reg), .neg(ny5_reg),
                      .t(tf5_reg), .pos(pcey));

    logic                 v6_reg, vis6_reg, use_c6_reg, use_f6_reg;
    logic signed [CW-1:0] sx6_reg, sy6_reg, ex6_reg, ey6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis6_reg   <= vis5_reg;
            use_c6_reg <= use_c5_reg;
            use_f6_reg <= use_f5_reg;
            sx6_reg    <= s5_reg.sx;
            sy6_reg    <= s5_reg.sy;
            ex6_reg    <= s5_reg.ex;
            ey6_reg    <= s5_reg.ey;
        end
    end

    logic                 vis_reg;
    logic signed [CW-1:0] csx_reg, csy_reg, cex_reg, cey_reg;
    logic                 out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg <= vis6_reg;
            csx_reg <= !vis6_reg ? '0 : (use_c6_reg ? pcsx : sx6_reg);
            csy_reg <= !vis6_reg ? '0 : (use_c6_reg ? pcsy : sy6_reg);
            cex_reg <= !vis6_reg ? '0 : (use_f6_reg ? pcex : ex6_reg);
            cey_reg <= !vis6_reg ? '0 : (use_f6_reg ? pcey : ey6_reg);
        end
    end

    // valid bits travel alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            dv_reg        <= '0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg        <= in_valid;
            dv_reg        <= {dv_reg[DL-2:0], v2_reg};
            v4_reg        <= dv_reg[DL-1];
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign visible         = vis_reg;
    assign clipped_start_x = csx_reg;
    assign clipped_start_y = csy_reg;
    assign clipped_end_x   = cex_reg;
    assign clipped_end_y   = cey_reg;

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> clipped_start_x == 0 && clipped_start_y == 0
                                  && clipped_end_x == 0 && clipped_end_y == 0)
        else $error("hidden segment with non-zero coordinates");

    a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(v4_reg) && $stable(dv_reg) && $stable(v6_reg))
        else $error("pipeline moved during stall");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |=> out_valid == $past(v6_reg))
        else $error("result beat lost or invented");

endmodule
`default_nettype wire

FILE: tb/tb_segment_box_clipper_core.sv
`default_nettype none
module tb_segment_box_clipper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint T1 = longint'(1) << sbc_pkg::PARAM_FRAC_BITS;
    localparam int     STALL_LIMIT = 3000;
    localparam int     LONG_HOLD = 300;

    typedef struct packed {
        logic                vis;
        logic signed [31:0]  csx;
        logic signed [31:0]  csy;
        logic signed [31:0]  cex;
        logic signed [31:0]  cey;
    } clip_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] start_x = '0;
    logic signed [31:0] start_y = '0;
    logic signed [31:0] end_x = '0;
    logic signed [31:0] end_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic visible;
    logic signed [31:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    sbc_pkg::cfg_idx_t cfg_index = sbc_pkg::CFG_X_MIN;
    logic [31:0] cfg_data = '0;

    segment_box_clipper_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .visible        (visible),
        .clipped_start_x(clipped_start_x),
        .clipped_start_y(clipped_start_y),
        .clipped_end_x  (clipped_end_x),
        .clipped_end_y  (clipped_end_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // local copy of the clip rectangle
    longint box_x0 = 0, box_y0 = 0, box_w = 0, box_h = 0;

    clip_res_t clip_q[$];
    int  mismatches = 0;
    int  checked = 0;
    int  visible_seen = 0;
    int  sent = 0;
    bit  idle_en = 1'b1;
    int  hold_seq = 0;
    int  quiet_cycles = 0;

    function automatic longint slab_ratio(longint num, longint den);
        bit neg;
        longint unsigned an, ad, q, r;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (an == 0)
            return 0;
        if (neg && an >= ad)
            return -T1;
        if (!neg && an >= 2 * ad)
            return 2 * T1;
        q = (an >= ad) ? 1 : 0;
        r = an - q * ad;
        for (int i = 0; i < sbc_pkg::PARAM_FRAC_BITS + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= ad)
            begin
                r = r - ad;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit slab(longint s, longint d, longint lo, longint hi,
                                output longint t_in, output longint t_out);
        longint a, b;
        if (d == 0)
        begin
            t_in = -T1;
            t_out = 2 * T1;
            return (s >= lo) && (s <= hi);
        end
        a = slab_ratio(lo - s, d);
        b = slab_ratio(hi - s, d);
        t_in = (a < b) ? a : b;
        t_out = (a < b) ? b : a;
        return 1'b1;
    endfunction

    // |d| < 2^33 and t < 2^24, so the product fits in 64 bits
    function automatic longint interp(longint s, longint d, longint t);
        longint unsigned ad, mag;
        ad = (d < 0) ? -d : d;
        mag = (ad * longint'(t) + (longint'(1) << (sbc_pkg::PARAM_FRAC_BITS - 1)))
              >> sbc_pkg::PARAM_FRAC_BITS;
        return (d < 0) ? s - longint'(mag) : s + longint'(mag);
    endfunction

    function automatic clip_res_t clip_segment(logic signed [31:0] a_x, logic signed [31:0] a_y,
                                               logic signed [31:0] b_x, logic signed [31:0] b_y);
        clip_res_t res;
        longint sx, sy, ex, ey, dx, dy, xin, xout, yin, yout, t_close, t_far;
        bit ok;
        res = '0;
        sx = longint'(a_x); sy = longint'(a_y); ex = longint'(b_x); ey = longint'(b_y);
        dx = ex - sx;
        dy = ey - sy;
        if (dx == 0 && dy == 0)
            return res;
        ok = slab(sx, dx, box_x0, box_x0 + box_w, xin, xout);
        ok = slab(sy, dy, box_y0, box_y0 + box_h, yin, yout) && ok;
        if (!ok || xin > yout || yin > xout)
            return res;
        t_close = (xin > yin) ? xin : yin;
        t_far = (xout < yout) ? xout : yout;
        if (!(t_far > 0 && t_close < T1))
            return res;
        res.vis = 1'b1;
        res.csx = 32'((t_close > 0) ? interp(sx, dx, t_close) : sx);
        res.csy = 32'((t_close > 0) ? interp(sy, dy, t_close) : sy);
        res.cex = 32'((t_far < T1) ? interp(sx, dx, t_far) : ex);
        res.cey = 32'((t_far < T1) ? interp(sy, dy, t_far) : ey);
        return res;
    endfunction

    // receiver: random stall bursts, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int burst, hold_left, hold_seen;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            burst = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        clip_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (clip_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want = clip_q.pop_front();
                checked++;
                if (want.vis)
                    visible_seen++;
                if (visible !== want.vis || clipped_start_x !== want.csx ||
                    clipped_start_y !== want.csy || clipped_end_x !== want.cex ||
                    clipped_end_y !== want.cey)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp vis=%0b %h %h %h %h, got vis=%0b %h %h %h %h",
                                 checked, want.vis, want.csx, want.csy, want.cex, want.cey,
                                 visible, clipped_start_x, clipped_start_y, clipped_end_x,
                                 clipped_end_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("tb_segment_box_clipper_core: errors");
            $finish;
        end
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(sbc_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sbc_pkg::CFG_X_MIN:  box_x0 = longint'(signed'(value));
            sbc_pkg::CFG_Y_MIN:  box_y0 = longint'(signed'(value));
            sbc_pkg::CFG_WIDTH:  box_w = longint'(value[30:0]);
            sbc_pkg::CFG_HEIGHT: box_h = longint'(value[30:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (clip_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] w, logic [31:0] h);
        drain();
        write_reg(sbc_pkg::CFG_X_MIN, x0);
        write_reg(sbc_pkg::CFG_Y_MIN, y0);
        write_reg(sbc_pkg::CFG_WIDTH, w);
        write_reg(sbc_pkg::CFG_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // called at a clock edge; valid stays high into the next beat if no gap
    task automatic send_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx, logic [31:0] by);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= ax;
        start_y <= ay;
        end_x <= bx;
        end_y <= by;
        do
            @(posedge clk);
        while (in_stall);
        clip_q.push_back(clip_segment(ax, ay, bx, by));
        sent++;
    endtask

    function automatic logic [31:0] fx(int v);
        return v <<< 16;
    endfunction

    // coordinate around the box edge lo..lo+span, clamped to 32 bits
    function automatic logic [31:0] near_box(longint lo, longint span);
        longint v, w;
        w = (span < 64) ? 64 : span;
        if (w > 64'h7fffffff)
            w = 64'h7fffffff;
        v = lo - w / 2 + longint'($urandom_range(0, 32'(2 * w)));
        if ($urandom_range(0, 5) == 0)
            v = lo + longint'($urandom_range(0, 4)) - 2;
        if (v > 64'sh7fffffff)
            v = 64'sh7fffffff;
        if (v < -64'sh80000000)
            v = -64'sh80000000;
        return v[31:0];
    endfunction

    task automatic send_random_segment();
        logic [31:0] ax, ay, bx, by;
        case ($urandom_range(0, 7))
            0:
            begin
                ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
            end
            1:
            begin
                // axis-parallel or degenerate
                ax = near_box(box_x0, box_w); ay = near_box(box_y0, box_h);
                bx = $urandom_range(0, 1) ? ax : near_box(box_x0, box_w);
                by = (bx == ax || $urandom_range(0, 1)) ? ay : near_box(box_y0, box_h);
            end
            default:
            begin
                ax = near_box(box_x0, box_w); ay = near_box(box_y0, box_h);
                bx = near_box(box_x0, box_w); by = near_box(box_y0, box_h);
            end
        endcase
        send_segment(ax, ay, bx, by);
    endtask

    task automatic send_random_batch(int n);
        repeat (n) send_random_segment();
        in_valid <= 1'b0;
    endtask

    task automatic test_reset_box();
        // registers still at reset: the box is a single point at the origin
        send_segment(fx(-1), fx(-1), fx(1), fx(1));
        send_segment(fx(-1), fx(0), fx(1), fx(0));
        send_segment(fx(0), fx(0), fx(0), fx(0));
        send_segment(fx(1), fx(1), fx(2), fx(3));
        in_valid <= 1'b0;
    endtask

    task automatic test_directed();
        set_box(fx(-10), fx(-5), fx(20), fx(10));
        send_segment(fx(-5), fx(-2), fx(5), fx(2));
        send_segment(fx(-20), fx(0), fx(20), fx(0));
        send_segment(fx(-20), fx(7), fx(20), fx(7));
        send_segment(fx(0), fx(-20), fx(0), fx(20));
        send_segment(fx(11), fx(-20), fx(11), fx(20));
        send_segment(fx(1), fx(1), fx(1), fx(1));
        send_segment(fx(-20), fx(-20), fx(20), fx(20));
        send_segment(fx(20), fx(20), fx(-20), fx(-20));
        send_segment(fx(-20), fx(4), fx(-4), fx(20));
        send_segment(fx(-10), fx(-20), fx(-10), fx(20));
        send_segment(fx(0), fx(0), fx(30), fx(3));
        send_segment(fx(12), fx(0), fx(30), fx(0));
        send_segment(fx(-20), fx(0), fx(-10), fx(0));
        send_segment(fx(10), fx(0), fx(20), fx(0));
        send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_segment(32'h80000000, 32'h00000000, 32'h7fffffff, 32'h00000001);
        send_segment(32'h00000001, 32'hffffffff, 32'hffff0001, 32'h00010003);
        in_valid <= 1'b0;
    endtask

    task automatic test_box_extremes();
        set_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_random_batch(60);
        set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_random_batch(40);
        set_box(fx(3), fx(-2), 32'h0, fx(6));
        send_random_batch(50);
        set_box(fx(-4), fx(1), fx(9), 32'h0);
        send_random_batch(50);
    endtask

    task automatic test_random_boxes();
        repeat (6)
        begin
            set_box($urandom, $urandom, $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30),
                    $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30));
            send_random_batch(90);
        end
    endtask

    task automatic test_backpressure();
        set_box(fx(-100), fx(-100), fx(200), fx(200));
        hold_seq++;
        send_random_batch(120);
    endtask

    task automatic test_pause_drain();
        @(posedge clk);
        send_random_batch(30);
        while (clip_q.size() != 0)
            @(posedge clk);
        send_random_batch(30);
    endtask

    task automatic test_full_rate();
        drain();
        idle_en = 1'b0;
        set_box(fx(-50), fx(-30), fx(100), fx(60));
        send_random_batch(120);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_box();
        test_directed();
        test_box_extremes();
        test_random_boxes();
        test_backpressure();
        test_pause_drain();
        test_full_rate();
        drain();
        $display("%0d segments sent, %0d results checked, %0d visible", sent, checked,
                 visible_seen);
        $display("boxes: reset point, extremes, zero width/height, random; long hold and drain");
        if (mismatches == 0 && clip_q.size() == 0)
            $display("tb_segment_box_clipper_core: clean");
        else
            $display("tb_segment_box_clipper_core: errors");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/sbc_pkg.sv
rtl/sbc_div.sv
rtl/sbc_interp.sv
rtl/segment_box_clipper_core.sv
tb/tb_segment_box_clipper_core.sv
